[sv/sqlx_pkg.sv]
// ----------------------------------------------------------------------------
// SQL lexer byte classifier package
// Shared types, byte constants and byte-class helpers for the lexer block.
// ----------------------------------------------------------------------------
`default_nettype none

package sqlx_pkg;

  // Byte constants
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  localparam logic [15:0] MAX_LEN_RESET = 16'd255;
  localparam logic [15:0] COUNT_SAT     = 16'hFFFF;

  // Result queue geometry
  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = $clog2(RES_DEPTH);
  localparam int RES_CW    = $clog2(RES_DEPTH + 1);

  typedef enum logic [2:0] {
    CLS_SPACE   = 3'd0,
    CLS_COMMENT = 3'd1,
    CLS_WORD    = 3'd2,
    CLS_SQ      = 3'd3,
    CLS_DQ      = 3'd4,
    CLS_OP      = 3'd5,
    CLS_SEP     = 3'd6
  } char_class_t;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_DASH     = 4'd1,
    ST_COMMENT  = 4'd2,
    ST_WORD     = 4'd3,
    ST_SQ       = 4'd4,
    ST_SQ_ESC   = 4'd5,
    ST_SQ_QUOTE = 4'd6,
    ST_DQ       = 4'd7,
    ST_OP       = 4'd8
  } lex_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [2:0] char_class;
    logic       token_start;
    logic       too_long;
    logic       last_out;
  } out_item_t;

  // Lexer context carried between the core and the top level
  typedef struct packed {
    lex_state_t  state;
    logic [15:0] count;
  } lex_ctx_t;

  function automatic logic is_space_byte(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_op_byte(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h7C, 8'h3D, 8'h21, 8'h3E, 8'h3C,
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25: r = 1'b1;
      default:                           r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_word_byte(input logic [7:0] c);
    logic r;
    r = 1'b1;
    if (c < CH_SPACE || c == CH_DEL || c == CH_SPACE) r = 1'b0;
    if (c == CH_COMMA || c == CH_LPAREN || c == CH_RPAREN || c == CH_SEMI) r = 1'b0;
    if (is_op_byte(c)) r = 1'b0;
    return r;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v < COUNT_SAT) ? v + 16'd1 : v;
  endfunction

endpackage

`default_nettype wire

[sv/sqlx_lex_core.sv]
// ----------------------------------------------------------------------------
// SQL lexer next-state and result logic
// Classifies one byte against the current lexer context and produces zero,
// one or two result transactions plus the updated context.
// ----------------------------------------------------------------------------
`default_nettype none

module sqlx_lex_core (
  input  sqlx_pkg::lex_ctx_t  ctx,
  input  logic [15:0]         max_token_len,
  input  sqlx_pkg::in_item_t  item,
  output sqlx_pkg::lex_ctx_t  ctx_next,
  output sqlx_pkg::out_item_t res0,
  output sqlx_pkg::out_item_t res1,
  output logic [1:0]          res_num
);
  import sqlx_pkg::*;

  // Boundary decision, independent of state
  logic        b_hold;
  char_class_t b_cls;
  logic        b_start;
  lex_state_t  b_state;
  logic [15:0] b_cnt;

  always_comb begin
    b_hold  = 1'b0;
    b_start = 1'b1;
    b_cnt   = 16'd1;
    b_cls   = CLS_WORD;
    b_state = ST_WORD;
    if (is_space_byte(item.ch)) begin
      b_cnt   = 16'd0;
      b_cls   = CLS_SPACE;
      b_start = 1'b0;
      b_state = ST_IDLE;
    end else if (item.ch == CH_DASH) begin
      b_hold  = 1'b1;
      b_cnt   = 16'd0;
      b_state = ST_DASH;
    end else if (item.ch == CH_SQUOTE) begin
      b_cls   = CLS_SQ;
      b_state = ST_SQ;
    end else if (item.ch == CH_DQUOTE) begin
      b_cls   = CLS_DQ;
      b_state = ST_DQ;
    end else if (is_op_byte(item.ch)) begin
      b_cls   = CLS_OP;
      b_state = ST_OP;
    end else if (!is_word_byte(item.ch)) begin
      b_cls   = CLS_SEP;
      b_state = ST_IDLE;
    end
  end

  // Resolve a held dash, then lex the byte itself
  logic        dash_emit;
  logic        dash_dash;
  lex_state_t  st_a;
  logic [15:0] cnt_a;
  logic        lex_emit;
  logic        lex_hold;
  char_class_t l_cls;
  logic        l_start;
  lex_state_t  st_b;
  logic [15:0] cnt_b;
  out_item_t   dash_res;
  out_item_t   lex_res;

  always_comb begin
    dash_dash = (ctx.state == ST_DASH) && (item.ch == CH_DASH);
    dash_emit = (ctx.state == ST_DASH);
    st_a      = ctx.state;
    cnt_a     = ctx.count;
    if (dash_emit && !dash_dash) begin
      st_a  = ST_OP;
      cnt_a = 16'd1;
    end

    lex_hold = 1'b0;
    l_cls    = CLS_WORD;
    l_start  = 1'b0;
    st_b     = st_a;
    cnt_b    = sat_inc(cnt_a);
    unique case (st_a)
      ST_COMMENT: begin
        cnt_b = 16'd0;
        l_cls = CLS_COMMENT;
        st_b  = (item.ch == CH_NL) ? ST_IDLE : ST_COMMENT;
      end
      ST_WORD: begin
        if (!is_word_byte(item.ch)) begin
          lex_hold = b_hold; l_cls = b_cls; l_start = b_start;
          st_b = b_state; cnt_b = b_cnt;
        end
      end
      ST_SQ: begin
        l_cls = CLS_SQ;
        if (item.ch == CH_BSLASH) st_b = ST_SQ_ESC;
        else if (item.ch == CH_SQUOTE) st_b = ST_SQ_QUOTE;
      end
      ST_SQ_ESC: begin
        l_cls = CLS_SQ;
        st_b  = ST_SQ;
      end
      ST_SQ_QUOTE: begin
        l_cls = CLS_SQ;
        st_b  = ST_SQ;
        if (item.ch != CH_SQUOTE) begin
          lex_hold = b_hold; l_cls = b_cls; l_start = b_start;
          st_b = b_state; cnt_b = b_cnt;
        end
      end
      ST_DQ: begin
        l_cls = CLS_DQ;
        st_b  = (item.ch == CH_DQUOTE) ? ST_IDLE : ST_DQ;
      end
      ST_OP: begin
        l_cls = CLS_OP;
        if (!is_op_byte(item.ch)) begin
          lex_hold = b_hold; l_cls = b_cls; l_start = b_start;
          st_b = b_state; cnt_b = b_cnt;
        end
      end
      default: begin
        lex_hold = b_hold; l_cls = b_cls; l_start = b_start;
        st_b = b_state; cnt_b = b_cnt;
      end
    endcase

    // Flush a dash held on the final byte as a one-byte operator
    if (lex_hold && item.last) begin
      cnt_b   = 16'd1;
      l_cls   = CLS_OP;
      l_start = 1'b1;
    end
    lex_emit = !lex_hold || item.last;

    // Double dash opens a comment
    if (dash_dash) begin
      st_b     = ST_COMMENT;
      cnt_b    = 16'd0;
      l_cls    = CLS_COMMENT;
      l_start  = 1'b0;
      lex_emit = 1'b1;
    end

    dash_res.char_out    = CH_DASH;
    dash_res.char_class  = dash_dash ? CLS_COMMENT : CLS_OP;
    dash_res.token_start = !dash_dash;
    dash_res.too_long    = dash_dash ? 1'b0 : (16'd1 > max_token_len);
    dash_res.last_out    = 1'b0;

    lex_res.char_out     = item.ch;
    lex_res.char_class   = l_cls;
    lex_res.token_start  = l_start;
    lex_res.too_long     = (cnt_b > max_token_len);
    lex_res.last_out     = item.last;
  end

  // Order results and close the text on the final byte
  always_comb begin
    res0    = dash_emit ? dash_res : lex_res;
    res1    = lex_res;
    res_num = {1'b0, dash_emit} + {1'b0, lex_emit};
    ctx_next.state = item.last ? ST_IDLE : st_b;
    ctx_next.count = item.last ? 16'd0 : cnt_b;
  end

endmodule

`default_nettype wire

[sv/sqlx_res_fifo.sv]
// ----------------------------------------------------------------------------
// SQL lexer result queue
// Small flop queue taking up to two result transactions per cycle and
// presenting one per cycle on the output channel unless it is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sqlx_res_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_num,
  input  sqlx_pkg::out_item_t push0,
  input  sqlx_pkg::out_item_t push1,
  output logic                room,
  output logic                valid,
  input  logic                stall,
  output sqlx_pkg::out_item_t data
);
  import sqlx_pkg::*;

  out_item_t           mem [RES_DEPTH];
  logic [RES_AW-1:0]   wr_ptr;
  logic [RES_AW-1:0]   rd_ptr;
  logic [RES_CW-1:0]   count;
  logic                pop;
  logic [RES_AW-1:0]   wr_ptr1;

  assign pop     = valid && !stall;
  assign valid   = (count != '0);
  assign data    = mem[rd_ptr];
  assign room    = (count <= RES_CW'(RES_DEPTH - 2));
  assign wr_ptr1 = wr_ptr + RES_AW'(1);

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_AW'(push_num);
      if (pop) rd_ptr <= rd_ptr + RES_AW'(1);
      count  <= count + RES_CW'(push_num) - RES_CW'(pop);
    end
  end

  // Store incoming results
  always_ff @(posedge clk) begin
    if (push_num != 2'd0) mem[wr_ptr] <= push0;
    if (push_num == 2'd2) mem[wr_ptr1] <= push1;
  end

endmodule

`default_nettype wire

[sv/sql_lexer_char_classifier_unit.sv]
// Bytes pass the input register, results the result queue. Throughput: one byte
// per cycle unless stalled, limited by the single-pass lexer core; a byte after a
// held dash yields two results, drained one per cycle by an unstalled result queue.
// Reset: lexer idle, token count zero, max_token_len 255, result queue empty.
// ----------------------------------------------------------------------------
// SQL lexer byte classifier, top level
// Input register, single-pass lexer core and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_lexer_char_classifier_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sqlx_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sqlx_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import sqlx_pkg::*;

  in_item_t    in_q;
  logic        in_vld;
  lex_ctx_t    ctx;
  lex_ctx_t    ctx_next;
  logic [15:0] max_token_len;
  out_item_t   res0;
  out_item_t   res1;
  logic [1:0]  res_num;
  logic        room;
  logic        proc;
  logic        in_accept;

  assign cfg_ready = 1'b1;
  assign proc      = in_vld && room;
  assign in_stall  = in_vld && !room;
  assign in_accept = in_valid && !in_stall;

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_token_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_token_len <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_accept) begin
      in_vld <= 1'b1;
    end else if (proc) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) in_q <= in_data;
  end

  // Advance lexer context on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state <= ST_IDLE;
      ctx.count <= '0;
    end else if (proc) begin
      ctx <= ctx_next;
    end
  end

  sqlx_lex_core u_core (
    .ctx           (ctx),
    .max_token_len (max_token_len),
    .item          (in_q),
    .ctx_next      (ctx_next),
    .res0          (res0),
    .res1          (res1),
    .res_num       (res_num)
  );

  sqlx_res_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_num (proc ? res_num : 2'd0),
    .push0    (res0),
    .push1    (res1),
    .room     (room),
    .valid    (out_valid),
    .stall    (out_stall),
    .data     (out_data)
  );

  // The final byte returns the lexer to idle with a cleared count
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    proc && in_q.last |=> ctx.state == ST_IDLE && ctx.count == 16'd0)
    else $error("lexer not idle after final byte");

  // Comments and a held dash never carry a token length
  a_no_count: assert property (@(posedge clk) disable iff (rst)
    (ctx.state == ST_COMMENT || ctx.state == ST_DASH) |-> ctx.count == 16'd0)
    else $error("token count set outside a token");

  // Results appear only after a processed byte
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(proc))
    else $error("result transaction without a processed byte");

endmodule

`default_nettype wire
